[rtl/sm3_pkg.sv]
// SM3 hash engine package: constants, types and round functions.
// Used by every module of the engine; depends on nothing.
`default_nettype none
package sm3_pkg;
  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam int unsigned LEN_SLOT = 56;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [255:0] IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

  // request passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage
`default_nettype wire

[rtl/sm3_hash_engine.sv]
// SM3 hash engine top level: byte stream in, digest words out.
// Flow: a block-filling byte or end request is accepted, then each block is loaded,
// run through the 64 rounds and folded (one or two padding blocks), then 8 digest words.
// Throughput: the queue takes one byte per cycle while not full; the back end takes no
// new byte while it is loading, compressing, folding or emitting a digest.
// Synchronous active-low reset restores the SM3 initial value and empties the queue.
`default_nettype none
module sm3_hash_engine #(
  parameter int unsigned FIFO_DEPTH = sm3_pkg::FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // byte_present
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast   // last_word
);
  sm3_pkg::req_t in_req, q_req;
  logic q_valid, q_ready;
  logic [31:0] w;
  logic [2:0]  idx;

  assign in_req = '{data_byte: in_tdata, byte_present: in_tuser,
                    end_of_message: in_tlast};

  sm3_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_req, .q_valid, .q_ready, .q_req);

  sm3_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(w), .out_index(idx), .out_last(out_tlast));

  assign out_tdata = {5'd0, idx, w};
endmodule
`default_nettype wire

[rtl/sm3_front.sv]
// SM3 front end: request queue between input channel and compression back end.
// Depends on sm3_pkg.
`default_nettype none
module sm3_front #(
  parameter int unsigned DEPTH = sm3_pkg::FIFO_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sm3_pkg::req_t  in_req,
  output logic                q_valid,
  input  wire logic           q_ready,
  output sm3_pkg::req_t       q_req
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  sm3_pkg::req_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic push, pop;

  // idle requests carry no work: drop them here
  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign push = in_valid && in_ready &&
                (in_req.byte_present || in_req.end_of_message);
  assign q_valid = (cnt_r != '0);
  assign pop = q_valid && q_ready;
  assign q_req = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[rtl/sm3_back.sv]
// SM3 back end: block buffer, padding, 64-round compression and digest output.
// Depends on sm3_pkg.
`default_nettype none
module sm3_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire sm3_pkg::req_t q_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_word,
  output logic [2:0]         out_index,
  output logic               out_last
);
  sm3_pkg::state_t st_r, st_nxt;
  // block buffer held as 16 big-endian words, byte 0 in the top lane
  logic [31:0]  buf_r [16];
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [255:0] cv_r;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0]  w_r [16];
  logic [5:0]   rnd_r;
  logic [3:0]   ld_r;
  logic         pad_r, fin_r, two_r, second_r, mark_r;
  logic [5:0]   nfill_r;
  logic [2:0]   oi_r;

  logic take;
  logic [31:0] ld_word;
  logic [31:0] tj, a12, s1, s2, ff, gg, t1, t2, wn;
  logic [5:0]  fill_inc;

  // byte of the block being compressed, padded as needed
  function automatic logic [7:0] pbyte(input logic [5:0] idx, input logic [7:0] raw,
      input logic pad, input logic second, input logic two, input logic [5:0] n,
      input logic [63:0] bits);
    logic [6:0] pos;
    logic lenblk;
    pos = {second, idx};
    lenblk = !two || second;
    if (!pad) return raw;
    if (lenblk && idx >= 6'd56) return bits[8*(63-idx) +: 8];
    if (pos < {1'b0, n}) return raw;
    if (pos == {1'b0, n}) return sm3_pkg::PAD_MARK;
    return 8'h00;
  endfunction

  assign fill_inc = fill_r + 6'd1;
  assign take = q_valid && q_ready;
  assign q_ready = (st_r == sm3_pkg::ST_IDLE);

  always_comb begin
    ld_word = '0;
    for (int k = 0; k < 4; k++)
      ld_word[8*(3-k) +: 8] = pbyte({ld_r, 2'(k)}, buf_r[ld_r][8*(3-k) +: 8],
        pad_r, second_r, two_r, nfill_r, bits_r);
  end

  // one round of compression, message expansion on the fly
  always_comb begin
    tj  = (rnd_r < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12 = sm3_pkg::rotl(a_r, 5'd12);
    s1  = sm3_pkg::rotl(a12 + e_r + sm3_pkg::rotl(tj, rnd_r[4:0]), 5'd7);
    s2  = s1 ^ a12;
    if (rnd_r < 6'd16) begin
      ff = a_r ^ b_r ^ c_r;
      gg = e_r ^ f_r ^ g_r;
    end else begin
      ff = (a_r & b_r) | (a_r & c_r) | (b_r & c_r);
      gg = (e_r & f_r) | (~e_r & g_r);
    end
    t1 = ff + d_r + s2 + (w_r[0] ^ w_r[4]);
    t2 = gg + h_r + s1 + w_r[0];
    wn = sm3_pkg::perm1(w_r[0] ^ w_r[7] ^ sm3_pkg::rotl(w_r[13], 5'd15)) ^
         sm3_pkg::rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sm3_pkg::ST_IDLE: if (take) begin
        if (q_req.byte_present && fill_r == 6'd63) st_nxt = sm3_pkg::ST_LOAD;
        else if (q_req.end_of_message) st_nxt = sm3_pkg::ST_LOAD;
      end
      sm3_pkg::ST_LOAD:  if (ld_r == 4'd15) st_nxt = sm3_pkg::ST_ROUND;
      sm3_pkg::ST_ROUND: if (rnd_r == 6'd63) st_nxt = sm3_pkg::ST_FOLD;
      sm3_pkg::ST_FOLD: begin
        if (pad_r && two_r && !second_r) st_nxt = sm3_pkg::ST_LOAD;
        else if (mark_r && fin_r) st_nxt = sm3_pkg::ST_LOAD;
        else if (fin_r) st_nxt = sm3_pkg::ST_EMIT;
        else st_nxt = sm3_pkg::ST_IDLE;
      end
      sm3_pkg::ST_EMIT: if (out_ready && oi_r == 3'd7) st_nxt = sm3_pkg::ST_IDLE;
      default: st_nxt = sm3_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = (st_r == sm3_pkg::ST_EMIT);
    out_word  = cv_r[32*(7-oi_r) +: 32];
    out_index = oi_r;
    out_last  = (oi_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (take && q_req.byte_present)
      buf_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= q_req.data_byte;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sm3_pkg::ST_IDLE;
      cv_r <= sm3_pkg::IV; fill_r <= '0; bits_r <= '0;
      ld_r <= '0; rnd_r <= '0; oi_r <= '0;
      pad_r <= 1'b0; fin_r <= 1'b0; two_r <= 1'b0; second_r <= 1'b0;
      mark_r <= 1'b0; nfill_r <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        sm3_pkg::ST_IDLE: if (take) begin
          ld_r <= '0; second_r <= 1'b0;
          fin_r <= q_req.end_of_message;
          mark_r <= q_req.byte_present && fill_r == 6'd63;
          if (q_req.byte_present) begin
            fill_r <= fill_inc;
            bits_r <= bits_r + 64'd8;
          end
          pad_r <= q_req.end_of_message && !(q_req.byte_present && fill_r == 6'd63);
          if (q_req.byte_present && fill_r == 6'd63) begin
            nfill_r <= '0; two_r <= 1'b0;
          end else begin
            nfill_r <= q_req.byte_present ? fill_inc : fill_r;
            two_r <= ((q_req.byte_present ? fill_inc : fill_r) >= 6'(sm3_pkg::LEN_SLOT));
          end
        end
        sm3_pkg::ST_LOAD: begin
          w_r[ld_r] <= ld_word;
          ld_r <= ld_r + 4'd1;
          rnd_r <= '0;
          {a_r,b_r,c_r,d_r,e_r,f_r,g_r,h_r} <= cv_r;
        end
        sm3_pkg::ST_ROUND: begin
          for (int k = 0; k < 15; k++) w_r[k] <= w_r[k+1];
          w_r[15] <= wn;
          d_r <= c_r; c_r <= sm3_pkg::rotl(b_r, 5'd9); b_r <= a_r; a_r <= t1;
          h_r <= g_r; g_r <= sm3_pkg::rotl(f_r, 5'd19); f_r <= e_r;
          e_r <= sm3_pkg::perm0(t2);
          rnd_r <= rnd_r + 6'd1;
        end
        sm3_pkg::ST_FOLD: begin
          cv_r <= cv_r ^ {a_r,b_r,c_r,d_r,e_r,f_r,g_r,h_r};
          ld_r <= '0;
          if (pad_r && two_r && !second_r) second_r <= 1'b1;
          else if (mark_r && fin_r) begin
            // full block done, now the padding block
            mark_r <= 1'b0; pad_r <= 1'b1;
          end
          oi_r <= '0;
        end
        sm3_pkg::ST_EMIT: if (out_ready) begin
          oi_r <= oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            cv_r <= sm3_pkg::IV; fill_r <= '0; bits_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
